/* rtl/lav_pkg.sv */
// Shared types, widths and register codes for the look-at view matrix block.
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;
	localparam int Q16_W = 32;
	localparam int AX_W = 18;
	localparam int NV_W = 36;
	localparam int LZ_W = 6;
	localparam int NS_W = 31;
	localparam int SQ_W = 64;
	localparam int RT_W = 32;
	localparam int RT_STEPS = 32;
	localparam int RM_W = 34;
	localparam int QT_W = 17;
	localparam int FRAC_W = 16;
	localparam int NUM_W = 48;
	localparam int PRD_W = 50;
	localparam int DOT_W = 52;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_UP_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_UP_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_UP_Z = 2'd2;

	localparam logic signed [AX_W-1:0] UP_X_RST = 18'sd0;
	localparam logic signed [AX_W-1:0] UP_Y_RST = 18'sd65536;
	localparam logic signed [AX_W-1:0] UP_Z_RST = 18'sd0;

	typedef logic signed [Q16_W-1:0] q16_t;
	typedef logic signed [AX_W-1:0] ax_t;
	typedef logic signed [NV_W-1:0] nv_t;

	typedef struct packed {
		q16_t eye_x;
		q16_t eye_y;
		q16_t eye_z;
		ax_t  back_x;
		ax_t  back_y;
		ax_t  back_z;
		ax_t  rgt_x;
		ax_t  rgt_y;
		ax_t  rgt_z;
	} side_t;
endpackage
`default_nettype wire

/* rtl/lav_nrm.sv */
// Pipelined vector normalizer: scale, square sum, square root and division.
`timescale 1ns / 1ps
`default_nettype none
module lav_nrm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire lav_pkg::nv_t    vin [3],
	input  wire lav_pkg::side_t  side_in,
	output logic                 valid_out,
	output lav_pkg::ax_t         vout [3],
	output lav_pkg::side_t       side_out
);
	localparam int NW = lav_pkg::NV_W;
	localparam int SW = lav_pkg::NS_W;
	localparam int LW = lav_pkg::LZ_W;
	localparam int QW = lav_pkg::QT_W;
	localparam int NU = lav_pkg::NUM_W;
	localparam int RS = lav_pkg::RT_STEPS;

	logic [NW-1:0] mag_c [3];
	logic [NW-1:0] max01_c, max_c;
	logic [LW-1:0] p_c;
	logic [SW-1:0] ns_c [3];

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [NW-1:0]        mag_s1 [3];
	logic [NW-1:0]        mag_s2 [3];
	logic [2:0]           neg_s1, neg_s2, neg_s3, neg_s4;
	logic [NW-1:0]        max_s1;
	logic [LW-1:0]        p_s2;
	logic                 zero_s2, zero_s3, zero_s4;
	logic [SW-1:0]        ns_s3 [3];
	logic [SW-1:0]        ns_s4 [3];
	logic [2*SW-1:0]      sqp_s4 [3];
	lav_pkg::side_t       side_s1, side_s2, side_s3, side_s4;

	logic                   rt_v_s    [RS+1];
	logic [lav_pkg::SQ_W-1:0] rt_src_s [RS+1];
	logic [lav_pkg::RM_W-1:0] rt_rem_s [RS+1];
	logic [lav_pkg::RT_W-1:0] rt_root_s [RS+1];
	logic [SW-1:0]          rt_ns_s   [RS+1][3];
	logic [2:0]             rt_neg_s  [RS+1];
	logic                   rt_zero_s [RS+1];
	lav_pkg::side_t         rt_side_s [RS+1];

	logic                   dv_v_s    [QW+1];
	logic [NU-1:0]          dv_rem_s  [QW+1][3];
	logic [QW-1:0]          dv_qt_s   [QW+1][3];
	logic [lav_pkg::RT_W-1:0] dv_len_s [QW+1];
	logic [2:0]             dv_neg_s  [QW+1];
	logic                   dv_zero_s [QW+1];
	lav_pkg::side_t         dv_side_s [QW+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vin[i][NW-1] ? NW'(-vin[i]) : NW'(vin[i]);
		end
		max01_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
		max_c = (max01_c > mag_c[2]) ? max01_c : mag_c[2];
	end

	always_comb begin
		p_c = '0;
		for (int i = 0; i < NW; i++) begin
			if (max_s1[i]) begin
				p_c = LW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (p_s2 > LW'(SW - 1)) begin
				ns_c[i] = SW'(mag_s2[i] >> (p_s2 - LW'(SW - 1)));
			end else begin
				ns_c[i] = SW'(mag_s2[i] << (LW'(SW - 1) - p_s2));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			rt_v_s[0] <= 1'b0;
		end else begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rt_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_c[i];
			neg_s1[i] <= vin[i][NW-1];
			mag_s2[i] <= mag_s1[i];
			ns_s3[i] <= ns_c[i];
			ns_s4[i] <= ns_s3[i];
			sqp_s4[i] <= (2*SW)'(ns_s3[i]) * (2*SW)'(ns_s3[i]);
			rt_ns_s[0][i] <= ns_s4[i];
		end
		max_s1 <= max_c;
		side_s1 <= side_in;
		p_s2 <= p_c;
		zero_s2 <= (max_s1 == '0);
		neg_s2 <= neg_s1;
		side_s2 <= side_s1;
		zero_s3 <= zero_s2;
		neg_s3 <= neg_s2;
		side_s3 <= side_s2;
		zero_s4 <= zero_s3;
		neg_s4 <= neg_s3;
		side_s4 <= side_s3;
		rt_src_s[0] <= lav_pkg::SQ_W'(sqp_s4[0]) + lav_pkg::SQ_W'(sqp_s4[1])
			+ lav_pkg::SQ_W'(sqp_s4[2]);
		rt_rem_s[0] <= '0;
		rt_root_s[0] <= '0;
		rt_neg_s[0] <= neg_s4;
		rt_zero_s[0] <= zero_s4;
		rt_side_s[0] <= side_s4;
	end

	for (genvar k = 0; k < RS; k++) begin : g_rt
		logic [lav_pkg::RM_W+1:0] pre;
		logic [lav_pkg::RM_W+1:0] trial;
		logic                     take;

		always_comb begin
			pre = {rt_rem_s[k], rt_src_s[k][lav_pkg::SQ_W-1 -: 2]};
			trial = (lav_pkg::RM_W + 2)'({rt_root_s[k], 2'b01});
			take = (pre >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_src_s[k+1] <= rt_src_s[k] << 2;
			if (take) begin
				rt_rem_s[k+1] <= lav_pkg::RM_W'(pre - trial);
				rt_root_s[k+1] <= {rt_root_s[k][lav_pkg::RT_W-2:0], 1'b1};
			end else begin
				rt_rem_s[k+1] <= lav_pkg::RM_W'(pre);
				rt_root_s[k+1] <= {rt_root_s[k][lav_pkg::RT_W-2:0], 1'b0};
			end
			rt_ns_s[k+1] <= rt_ns_s[k];
			rt_neg_s[k+1] <= rt_neg_s[k];
			rt_zero_s[k+1] <= rt_zero_s[k];
			rt_side_s[k+1] <= rt_side_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= rt_v_s[RS];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= (NU'(rt_ns_s[RS][i]) << lav_pkg::FRAC_W)
				+ NU'(rt_root_s[RS] >> 1);
			dv_qt_s[0][i] <= '0;
		end
		dv_len_s[0] <= rt_root_s[RS];
		dv_neg_s[0] <= rt_neg_s[RS];
		dv_zero_s[0] <= rt_zero_s[RS];
		dv_side_s[0] <= rt_side_s[RS];
	end

	for (genvar d = 0; d < QW; d++) begin : g_dv
		logic [NU:0] dvs;

		assign dvs = (NU + 1)'(dv_len_s[d]) << (QW - 1 - d);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[d+1] <= 1'b0;
			end else begin
				dv_v_s[d+1] <= dv_v_s[d];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, dv_rem_s[d][i]} >= dvs) begin
					dv_rem_s[d+1][i] <= NU'({1'b0, dv_rem_s[d][i]} - dvs);
					dv_qt_s[d+1][i] <= {dv_qt_s[d][i][QW-2:0], 1'b1};
				end else begin
					dv_rem_s[d+1][i] <= dv_rem_s[d][i];
					dv_qt_s[d+1][i] <= {dv_qt_s[d][i][QW-2:0], 1'b0};
				end
			end
			dv_len_s[d+1] <= dv_len_s[d];
			dv_neg_s[d+1] <= dv_neg_s[d];
			dv_zero_s[d+1] <= dv_zero_s[d];
			dv_side_s[d+1] <= dv_side_s[d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[QW]) begin
				vout[i] <= '0;
			end else if (dv_neg_s[QW][i]) begin
				vout[i] <= -lav_pkg::ax_t'({1'b0, dv_qt_s[QW][i]});
			end else begin
				vout[i] <= lav_pkg::ax_t'({1'b0, dv_qt_s[QW][i]});
			end
		end
		side_out <= dv_side_s[QW];
	end
endmodule
`default_nettype wire

/* rtl/lav_cross.sv */
// Two-stage cross product of two unit-scale vectors.
`timescale 1ns / 1ps
`default_nettype none
module lav_cross (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire lav_pkg::ax_t    a [3],
	input  wire lav_pkg::ax_t    b [3],
	input  wire lav_pkg::side_t  side_in,
	output logic                 valid_out,
	output lav_pkg::nv_t         r [3],
	output lav_pkg::side_t       side_out
);
	localparam int PW = 2 * lav_pkg::AX_W;

	logic                v_s1;
	logic signed [PW-1:0] pp_s1 [6];
	lav_pkg::side_t      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			valid_out <= 1'b0;
		end else begin
			v_s1 <= valid_in;
			valid_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1[0] <= PW'(a[1]) * PW'(b[2]);
		pp_s1[1] <= PW'(a[2]) * PW'(b[1]);
		pp_s1[2] <= PW'(a[2]) * PW'(b[0]);
		pp_s1[3] <= PW'(a[0]) * PW'(b[2]);
		pp_s1[4] <= PW'(a[0]) * PW'(b[1]);
		pp_s1[5] <= PW'(a[1]) * PW'(b[0]);
		side_s1 <= side_in;
		for (int i = 0; i < 3; i++) begin
			r[i] <= lav_pkg::nv_t'((PW + 1)'(pp_s1[2*i]) - (PW + 1)'(pp_s1[2*i+1]));
		end
		side_out <= side_s1;
	end
endmodule
`default_nettype wire

/* rtl/lav_xlat.sv */
// Translation column: negated dot products, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module lav_xlat (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire lav_pkg::q16_t   eye [3],
	input  wire lav_pkg::ax_t    rgt [3],
	input  wire lav_pkg::ax_t    cup [3],
	input  wire lav_pkg::ax_t    bak [3],
	output logic                 valid_out,
	output lav_pkg::ax_t         rgt_out [3],
	output lav_pkg::ax_t         cup_out [3],
	output lav_pkg::ax_t         bak_out [3],
	output lav_pkg::q16_t        shift [3]
);
	localparam int PW = lav_pkg::PRD_W;
	localparam int DW = lav_pkg::DOT_W;
	localparam int RW = DW - lav_pkg::FRAC_W;
	localparam int QW = lav_pkg::Q16_W;

	logic                 v_s1, v_s2;
	logic signed [PW-1:0] prd_s1 [3][3];
	logic signed [DW-1:0] dot_s2 [3];
	lav_pkg::ax_t         ax_s1 [3][3];
	lav_pkg::ax_t         ax_s2 [3][3];
	logic                 neg_c [3];
	logic [DW-1:0]        mag_c [3];
	logic [RW-1:0]        rnd_c [3];
	lav_pkg::q16_t        sat_c [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			neg_c[a] = dot_s2[a][DW-1];
			mag_c[a] = neg_c[a] ? DW'(-dot_s2[a]) : DW'(dot_s2[a]);
			rnd_c[a] = RW'((mag_c[a] + DW'(1 << (lav_pkg::FRAC_W - 1))) >> lav_pkg::FRAC_W);
			if (!neg_c[a]) begin
				if (rnd_c[a] > RW'({1'b0, {(QW - 1){1'b1}}})) begin
					sat_c[a] = {1'b0, {(QW - 1){1'b1}}};
				end else begin
					sat_c[a] = QW'(rnd_c[a]);
				end
			end else begin
				if (rnd_c[a] > RW'({1'b1, {(QW - 1){1'b0}}})) begin
					sat_c[a] = {1'b1, {(QW - 1){1'b0}}};
				end else begin
					sat_c[a] = -QW'(rnd_c[a]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			valid_out <= 1'b0;
		end else begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			valid_out <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prd_s1[0][i] <= PW'(eye[i]) * PW'(rgt[i]);
			prd_s1[1][i] <= PW'(eye[i]) * PW'(cup[i]);
			prd_s1[2][i] <= PW'(eye[i]) * PW'(bak[i]);
			ax_s1[0][i] <= rgt[i];
			ax_s1[1][i] <= cup[i];
			ax_s1[2][i] <= bak[i];
		end
		for (int a = 0; a < 3; a++) begin
			dot_s2[a] <= -(DW'(prd_s1[a][0]) + DW'(prd_s1[a][1]) + DW'(prd_s1[a][2]));
			for (int i = 0; i < 3; i++) begin
				ax_s2[a][i] <= ax_s1[a][i];
			end
			shift[a] <= sat_c[a];
		end
		for (int i = 0; i < 3; i++) begin
			rgt_out[i] <= ax_s2[0][i];
			cup_out[i] <= ax_s2[1][i];
			bak_out[i] <= ax_s2[2][i];
		end
	end
endmodule
`default_nettype wire

/* rtl/look_at_view_matrix_top.sv */
// Top level of the fixed-point look-at view matrix pipeline.
// Pulse start with the eye and aim coordinates (signed Q16.16) to submit
// one word. Busy is always low, so a new word can be started in every cycle.
// Each word produces one result word, marked by a
// one-cycle pulse on done together with the three unit axes (Q2.16) and
// the three saturated translations (Q16.16). Results cannot be held off.
// The path runs through three normalizer pipelines, each built around
// the 32-step square root and the 17-step divider, plus two cross
// product stages twice, one input stage and three stages for the
// translation column. Throughput is one word per cycle.
// The world up vector is written through the cfg channel, which is always
// ready; register 0 is x, 1 is y, 2 is z, and other indexes are ignored.
// Write it only while no word is in flight.
// Reset clears the pipeline valid bits and sets the up vector to (0, 1, 0).
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire lav_pkg::q16_t         eye_x,
	input  wire lav_pkg::q16_t         eye_y,
	input  wire lav_pkg::q16_t         eye_z,
	input  wire lav_pkg::q16_t         aim_x,
	input  wire lav_pkg::q16_t         aim_y,
	input  wire lav_pkg::q16_t         aim_z,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [lav_pkg::IDX_W-1:0] cfg_index,
	input  wire lav_pkg::ax_t          cfg_data,
	output logic                       done,
	output lav_pkg::ax_t               right_x,
	output lav_pkg::ax_t               right_y,
	output lav_pkg::ax_t               right_z,
	output lav_pkg::ax_t               cam_up_x,
	output lav_pkg::ax_t               cam_up_y,
	output lav_pkg::ax_t               cam_up_z,
	output lav_pkg::ax_t               back_x,
	output lav_pkg::ax_t               back_y,
	output lav_pkg::ax_t               back_z,
	output lav_pkg::q16_t              shift_right,
	output lav_pkg::q16_t              shift_up,
	output lav_pkg::q16_t              shift_back
);
	localparam int NW = lav_pkg::NV_W;

	lav_pkg::ax_t   up_x_q, up_y_q, up_z_q;
	logic           v_s1;
	lav_pkg::nv_t   diff_s1 [3];
	lav_pkg::side_t side_s1;

	logic           n0_v, c1_v, n1_v, c2_v, n2_v, x_v;
	lav_pkg::ax_t   back_n [3];
	lav_pkg::ax_t   rgt_n [3];
	lav_pkg::ax_t   cup_n [3];
	lav_pkg::ax_t   up_v [3];
	lav_pkg::ax_t   back_c2 [3];
	lav_pkg::ax_t   back_x3 [3];
	lav_pkg::ax_t   rgt_x3 [3];
	lav_pkg::q16_t  eye_x3 [3];
	lav_pkg::nv_t   c1_r [3];
	lav_pkg::nv_t   c2_r [3];
	lav_pkg::side_t n0_side, c1_in_side, c1_side, n1_side, c2_in_side, c2_side, n2_side;
	lav_pkg::ax_t   o_rgt [3];
	lav_pkg::ax_t   o_cup [3];
	lav_pkg::ax_t   o_bak [3];
	lav_pkg::q16_t  o_shift [3];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= lav_pkg::UP_X_RST;
			up_y_q <= lav_pkg::UP_Y_RST;
			up_z_q <= lav_pkg::UP_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lav_pkg::REG_UP_X: up_x_q <= cfg_data;
				lav_pkg::REG_UP_Y: up_y_q <= cfg_data;
				lav_pkg::REG_UP_Z: up_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1[0] <= NW'(eye_x) - NW'(aim_x);
		diff_s1[1] <= NW'(eye_y) - NW'(aim_y);
		diff_s1[2] <= NW'(eye_z) - NW'(aim_z);
		side_s1 <= '{eye_x: eye_x, eye_y: eye_y, eye_z: eye_z, default: '0};
	end

	lav_nrm u_nrm_back (
		.clk(clk), .arst_n(arst_n), .valid_in(v_s1), .vin(diff_s1), .side_in(side_s1),
		.valid_out(n0_v), .vout(back_n), .side_out(n0_side)
	);

	always_comb begin
		up_v[0] = up_x_q;
		up_v[1] = up_y_q;
		up_v[2] = up_z_q;
		c1_in_side = n0_side;
		c1_in_side.back_x = back_n[0];
		c1_in_side.back_y = back_n[1];
		c1_in_side.back_z = back_n[2];
	end

	lav_cross u_cross_right (
		.clk(clk), .arst_n(arst_n), .valid_in(n0_v), .a(up_v), .b(back_n),
		.side_in(c1_in_side), .valid_out(c1_v), .r(c1_r), .side_out(c1_side)
	);

	lav_nrm u_nrm_right (
		.clk(clk), .arst_n(arst_n), .valid_in(c1_v), .vin(c1_r), .side_in(c1_side),
		.valid_out(n1_v), .vout(rgt_n), .side_out(n1_side)
	);

	always_comb begin
		back_c2[0] = n1_side.back_x;
		back_c2[1] = n1_side.back_y;
		back_c2[2] = n1_side.back_z;
		c2_in_side = n1_side;
		c2_in_side.rgt_x = rgt_n[0];
		c2_in_side.rgt_y = rgt_n[1];
		c2_in_side.rgt_z = rgt_n[2];
	end

	lav_cross u_cross_up (
		.clk(clk), .arst_n(arst_n), .valid_in(n1_v), .a(back_c2), .b(rgt_n),
		.side_in(c2_in_side), .valid_out(c2_v), .r(c2_r), .side_out(c2_side)
	);

	lav_nrm u_nrm_up (
		.clk(clk), .arst_n(arst_n), .valid_in(c2_v), .vin(c2_r), .side_in(c2_side),
		.valid_out(n2_v), .vout(cup_n), .side_out(n2_side)
	);

	always_comb begin
		eye_x3[0] = n2_side.eye_x;
		eye_x3[1] = n2_side.eye_y;
		eye_x3[2] = n2_side.eye_z;
		back_x3[0] = n2_side.back_x;
		back_x3[1] = n2_side.back_y;
		back_x3[2] = n2_side.back_z;
		rgt_x3[0] = n2_side.rgt_x;
		rgt_x3[1] = n2_side.rgt_y;
		rgt_x3[2] = n2_side.rgt_z;
	end

	lav_xlat u_xlat (
		.clk(clk), .arst_n(arst_n), .valid_in(n2_v), .eye(eye_x3),
		.rgt(rgt_x3), .cup(cup_n), .bak(back_x3),
		.valid_out(x_v), .rgt_out(o_rgt), .cup_out(o_cup), .bak_out(o_bak),
		.shift(o_shift)
	);

	assign done = x_v;
	assign right_x = o_rgt[0];
	assign right_y = o_rgt[1];
	assign right_z = o_rgt[2];
	assign cam_up_x = o_cup[0];
	assign cam_up_y = o_cup[1];
	assign cam_up_z = o_cup[2];
	assign back_x = o_bak[0];
	assign back_y = o_bak[1];
	assign back_z = o_bak[2];
	assign shift_right = o_shift[0];
	assign shift_up = o_shift[1];
	assign shift_back = o_shift[2];
endmodule
`default_nettype wire

/* tb/look_at_view_matrix_top_tb.sv */
// Self-checking testbench for the look-at view matrix block, with a scoreboard class.
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_top_tb;
	import lav_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PIPE_WAIT = 200;

	typedef longint vec3_t[3];

	typedef struct {
		ax_t rx, ry, rz, ux, uy, uz, bx, by, bz;
		q16_t sr, su, sb;
	} view_t;

	class view_scoreboard;
		ax_t up_x, up_y, up_z;
		view_t expected_views[$];
		int mismatches;

		function new();
			up_x = UP_X_RST;
			up_y = UP_Y_RST;
			up_z = UP_Z_RST;
			mismatches = 0;
		endfunction

		function void write_up(logic [IDX_W-1:0] idx, ax_t data);
			case (idx)
				REG_UP_X: up_x = data;
				REG_UP_Y: up_y = data;
				REG_UP_Z: up_z = data;
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned root, bits;
			root = 0;
			bits = 64'd1 << 62;
			while (bits > n) bits >>= 2;
			while (bits != 0) begin
				if (n >= root + bits) begin
					n -= root + bits;
					root = (root >> 1) + bits;
				end else begin
					root >>= 1;
				end
				bits >>= 2;
			end
			return root;
		endfunction

		function void unit_vector(input vec3_t v, output vec3_t o);
			longint unsigned mag[3];
			longint unsigned m, sq, len, q;
			bit neg[3];
			int s;
			m = 0;
			sq = 0;
			s = 0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = v[i] < 0;
				mag[i] = neg[i] ? -v[i] : v[i];
				if (mag[i] > m) m = mag[i];
			end
			if (m == 0) begin
				o[0] = 0;
				o[1] = 0;
				o[2] = 0;
				return;
			end
			if (m >= (64'd1 << 31)) begin
				while ((m >> s) >= (64'd1 << 31)) s++;
				for (int i = 0; i < 3; i++) mag[i] >>= s;
			end else begin
				while ((m << s) < (64'd1 << 30)) s++;
				for (int i = 0; i < 3; i++) mag[i] <<= s;
			end
			for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
			len = int_sqrt(sq);
			for (int i = 0; i < 3; i++) begin
				q = (mag[i] * 64'd65536 + (len >> 1)) / len;
				o[i] = neg[i] ? -longint'(q) : longint'(q);
			end
		endfunction

		function void cross_prod(input vec3_t a, input vec3_t b, output vec3_t r);
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		function q16_t shift_of(vec3_t eye, vec3_t ax);
			longint t, r;
			longint unsigned mag;
			bit neg;
			t = -(eye[0] * ax[0] + eye[1] * ax[1] + eye[2] * ax[2]);
			neg = t < 0;
			mag = neg ? -t : t;
			r = longint'((mag + 64'd32768) >> 16);
			if (neg) r = -r;
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return q16_t'(r);
		endfunction

		function void note_input(q16_t ex, q16_t ey, q16_t ez, q16_t ax, q16_t ay, q16_t az);
			vec3_t eye, diff, up, bk, tmp, rt, cu;
			view_t w;
			eye = '{longint'(ex), longint'(ey), longint'(ez)};
			diff = '{eye[0] - longint'(ax), eye[1] - longint'(ay), eye[2] - longint'(az)};
			up = '{longint'(up_x), longint'(up_y), longint'(up_z)};
			unit_vector(diff, bk);
			cross_prod(up, bk, tmp);
			unit_vector(tmp, rt);
			cross_prod(bk, rt, tmp);
			unit_vector(tmp, cu);
			w.rx = ax_t'(rt[0]);
			w.ry = ax_t'(rt[1]);
			w.rz = ax_t'(rt[2]);
			w.ux = ax_t'(cu[0]);
			w.uy = ax_t'(cu[1]);
			w.uz = ax_t'(cu[2]);
			w.bx = ax_t'(bk[0]);
			w.by = ax_t'(bk[1]);
			w.bz = ax_t'(bk[2]);
			w.sr = shift_of(eye, rt);
			w.su = shift_of(eye, cu);
			w.sb = shift_of(eye, bk);
			expected_views.push_back(w);
		endfunction

		function void compare(string name, longint e, longint a);
			if (e != a) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch on %s: expected %0d, got %0d", name, e, a);
			end
		endfunction

		function void check_result(view_t got);
			view_t w;
			if (expected_views.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Result word with no input pending");
				return;
			end
			w = expected_views.pop_front();
			compare("right_x", w.rx, got.rx);
			compare("right_y", w.ry, got.ry);
			compare("right_z", w.rz, got.rz);
			compare("cam_up_x", w.ux, got.ux);
			compare("cam_up_y", w.uy, got.uy);
			compare("cam_up_z", w.uz, got.uz);
			compare("back_x", w.bx, got.bx);
			compare("back_y", w.by, got.by);
			compare("back_z", w.bz, got.bz);
			compare("shift_right", w.sr, got.sr);
			compare("shift_up", w.su, got.su);
			compare("shift_back", w.sb, got.sb);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	q16_t eye_x = '0, eye_y = '0, eye_z = '0, aim_x = '0, aim_y = '0, aim_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = REG_UP_X;
	ax_t cfg_data = '0;
	logic done;
	ax_t right_x, right_y, right_z, cam_up_x, cam_up_y, cam_up_z, back_x, back_y, back_z;
	q16_t shift_right, shift_up, shift_back;

	view_scoreboard sb = new();

	look_at_view_matrix_top DUT (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		view_t got;
		if (done) begin
			got = '{right_x, right_y, right_z, cam_up_x, cam_up_y, cam_up_z,
				back_x, back_y, back_z, shift_right, shift_up, shift_back};
			sb.check_result(got);
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, ax_t data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_up(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_up(ax_t x, ax_t y, ax_t z);
		write_reg(REG_UP_X, x);
		write_reg(REG_UNUSED, ax_t'($urandom));
		write_reg(REG_UP_Y, y);
		write_reg(REG_UP_Z, z);
	endtask

	task automatic wait_idle();
		while (sb.expected_views.size() != 0) @(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	// The word is driven at the falling edge and held until accepted.
	task automatic send_word(q16_t ex, q16_t ey, q16_t ez, q16_t ax, q16_t ay, q16_t az,
			int gap);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		start = 1'b1;
		eye_x = ex;
		eye_y = ey;
		eye_z = ez;
		aim_x = ax;
		aim_y = ay;
		aim_z = az;
		do @(posedge clk); while (busy);
		sb.note_input(ex, ey, ez, ax, ay, az);
	endtask

	task automatic stop_words();
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic int pick_gap(bit burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic q16_t pick_coord();
		case ($urandom_range(0, 3))
			0: return q16_t'($urandom);
			1: return q16_t'($urandom_range(0, 32'h0020_0000)) - q16_t'(32'h0010_0000);
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return q16_t'($urandom_range(0, 255)) - 128;
		endcase
	endfunction

	function automatic ax_t pick_up();
		case ($urandom_range(0, 4))
			0: return 18'sh1FFFF;
			1: return 18'sh20000;
			2: return '0;
			default: return ax_t'($urandom);
		endcase
	endfunction

	task automatic random_words(int count);
		q16_t e[3], a[3];
		bit burst;
		burst = 1'b0;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 49) == 0) burst = ~burst;
			foreach (e[i]) e[i] = pick_coord();
			case ($urandom_range(0, 9))
				0: a = e;
				1, 2, 3: foreach (a[i]) a[i] = e[i] + (q16_t'($urandom_range(0, 511)) - 256);
				4: begin
					a = e;
					a[$urandom_range(0, 2)] = pick_coord();
				end
				default: foreach (a[i]) a[i] = pick_coord();
			endcase
			send_word(e[0], e[1], e[2], a[0], a[1], a[2], pick_gap(burst));
		end
		stop_words();
	endtask

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// Directed words under the reset up vector.
		send_word(0, 0, 0, 0, 0, 0, 0);
		send_word(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0);
		send_word(0, 32'sh0005_0000, 0, 0, 0, 0, 1);
		send_word(0, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0);
		send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
		send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 2);
		send_word(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 0, 0);
		send_word(0, 0, 32'sh0001_0000, 0, 0, 0, 0);
		send_word(32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0);
		send_word(1, 0, 0, 0, 0, 0, 0);
		send_word(0, 0, 0, 0, 0, 1, 0);
		send_word(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 0, 0, 0, 5);
		send_word(32'sh7FFF_0000, 32'sh8001_0000, 32'sh1234_5678, 0, 0, 0, 0);
		send_word(32'sh8000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF, 1, 2, 3, 0);
		stop_words();
		wait_idle();

		set_up('0, '0, '0);
		send_word(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0, 0);
		send_word(32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0);
		stop_words();
		wait_idle();

		set_up(18'sh1FFFF, 18'sh20000, 18'sh1FFFF);
		send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0);
		send_word(32'sh0001_0000, 32'sh8000_0000, 32'sh0001_0000, 0, 0, 0, 0);
		random_words(200);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) set_up(UP_X_RST, UP_Y_RST, UP_Z_RST);
			else set_up(pick_up(), pick_up(), pick_up());
			random_words(220);
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.expected_views.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
rtl/lav_pkg.sv
rtl/lav_nrm.sv
rtl/lav_cross.sv
rtl/lav_xlat.sv
rtl/look_at_view_matrix_top.sv
tb/look_at_view_matrix_top_tb.sv
